@@ hw/rtl/twd_pkg.sv @@
`timescale 1ns / 1ps

package twd_pkg;

    // Operation codes carried in the action field
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_SEARCH = 2'd1;
    localparam logic [1:0] ACT_PREFIX = 2'd2;
    localparam logic [1:0] ACT_SPARE  = 2'd3;

    // Controller states, one-hot
    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_LOOK   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear_step;
        logic load;
        logic walk;
        logic finish;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic clear_done;
        logic item_last;
        logic out_free;
    } sts_t;

endpackage

@@ hw/rtl/twd_ctrl.sv @@
`timescale 1ns / 1ps

module twd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  twd_pkg::sts_t sts,
    output twd_pkg::cmd_t cmd
);

    twd_pkg::state_t state_reg;
    twd_pkg::state_t state_next;

    // Advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= twd_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        case (state_reg)
            twd_pkg::S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = twd_pkg::S_IDLE;
                end
            end
            twd_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = twd_pkg::S_LOOK;
                end
            end
            twd_pkg::S_LOOK:
            begin
                cmd.walk = 1'b1;
                if (sts.item_last)
                begin
                    state_next = twd_pkg::S_FINISH;
                end
                else
                begin
                    state_next = twd_pkg::S_IDLE;
                end
            end
            twd_pkg::S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = twd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = twd_pkg::S_CLEAR;
            end
        endcase
    end

    assign in_ready = (state_reg == twd_pkg::S_IDLE);

endmodule

@@ hw/rtl/twd_datapath.sv @@
`timescale 1ns / 1ps

module twd_datapath #(
    parameter int POOL_NODES    = 1024,
    parameter int ALPHABET_SIZE = 26
) (
    input  logic          clk,
    input  logic          rst_n,
    input  twd_pkg::cmd_t cmd,
    output twd_pkg::sts_t sts,
    input  logic [1:0]    action,
    input  logic [4:0]    letter,
    input  logic          empty_word,
    input  logic          is_last,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          found,
    output logic          pool_full
);

    localparam int LINK_DEPTH = POOL_NODES * ALPHABET_SIZE;
    localparam int NODE_W     = $clog2(POOL_NODES);
    localparam int FREE_W     = $clog2(POOL_NODES + 1);
    localparam int ADDR_W     = $clog2(LINK_DEPTH);

    // Link store and end-mark store
    logic [NODE_W-1:0] link_mem [0:LINK_DEPTH-1];
    logic              mark_mem [0:POOL_NODES-1];

    // Walk state
    logic [NODE_W-1:0] cur_node_reg;
    logic              missed_reg;
    logic [FREE_W-1:0] next_free_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;

    // Item held during the walk
    logic [1:0]        act_reg;
    logic              empty_reg;
    logic              last_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [NODE_W-1:0] link_rdata_reg;
    logic              mark_rdata_reg;

    // Result register
    logic              out_valid_reg;
    logic              found_reg;
    logic              pool_full_reg;

    logic [4:0]        letter_sat;
    logic [ADDR_W-1:0] in_addr;
    logic [1:0]        act_in;
    logic              do_step;
    logic              link_zero;
    logic              pool_out;
    logic              alloc;
    logic              miss_now;
    logic [NODE_W-1:0] cur_next;
    logic              found_next;
    logic              full_next;
    logic              mark_set;

    // Clamp the letter, form the link address and map the spare action to prefix
    always_comb
    begin
        if ({27'd0, letter} >= ALPHABET_SIZE)
        begin
            letter_sat = 5'(ALPHABET_SIZE - 1);
        end
        else
        begin
            letter_sat = letter;
        end
        in_addr = ADDR_W'(cur_node_reg) * ADDR_W'(ALPHABET_SIZE) + ADDR_W'(letter_sat);
        act_in  = (action == twd_pkg::ACT_SPARE) ? twd_pkg::ACT_PREFIX : action;
    end

    // Step one trie level using the link just read
    always_comb
    begin
        do_step   = !empty_reg && !missed_reg;
        link_zero = (link_rdata_reg == '0);
        pool_out  = (next_free_reg >= FREE_W'(POOL_NODES));
        alloc     = do_step && link_zero && (act_reg == twd_pkg::ACT_INSERT) && !pool_out;
        miss_now  = do_step && link_zero && !alloc;
        if (!do_step || miss_now)
        begin
            cur_next = cur_node_reg;
        end
        else if (alloc)
        begin
            cur_next = next_free_reg[NODE_W-1:0];
        end
        else
        begin
            cur_next = link_rdata_reg;
        end
    end

    // Form the result of the word
    always_comb
    begin
        found_next = 1'b0;
        full_next  = 1'b0;
        mark_set   = 1'b0;
        case (act_reg)
            twd_pkg::ACT_INSERT:
            begin
                found_next = !missed_reg;
                full_next  = missed_reg;
                mark_set   = !missed_reg;
            end
            twd_pkg::ACT_SEARCH:
            begin
                found_next = !missed_reg && mark_rdata_reg;
            end
            default:
            begin
                found_next = !missed_reg;
            end
        endcase
    end

    // Link store port: clear, allocate, read
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            link_mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.walk && alloc)
        begin
            link_mem[addr_reg] <= next_free_reg[NODE_W-1:0];
        end
        if (cmd.load)
        begin
            link_rdata_reg <= link_mem[in_addr];
        end
    end

    // End-mark store port: clear, mark, read
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step && ({{(32-ADDR_W){1'b0}}, clr_cnt_reg} < POOL_NODES))
        begin
            mark_mem[clr_cnt_reg[NODE_W-1:0]] <= 1'b0;
        end
        else if (cmd.finish && mark_set)
        begin
            mark_mem[cur_node_reg] <= 1'b1;
        end
        if (cmd.walk)
        begin
            mark_rdata_reg <= mark_mem[cur_next];
        end
    end

    // Hold the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= act_in;
            empty_reg <= empty_word;
            last_reg  <= is_last;
            addr_reg  <= in_addr;
        end
    end

    // Walk state and clearing counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_node_reg  <= '0;
            missed_reg    <= 1'b0;
            next_free_reg <= FREE_W'(1);
            clr_cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.walk)
            begin
                cur_node_reg <= cur_next;
                if (miss_now)
                begin
                    missed_reg <= 1'b1;
                end
                if (alloc)
                begin
                    next_free_reg <= next_free_reg + 1'b1;
                end
            end
            else if (cmd.finish)
            begin
                cur_node_reg <= '0;
                missed_reg   <= 1'b0;
            end
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            found_reg     <= found_next;
            pool_full_reg <= full_next;
        end
    end

    assign sts.clear_done = (clr_cnt_reg == ADDR_W'(LINK_DEPTH - 1));
    assign sts.item_last  = last_reg;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign pool_full = pool_full_reg;

    // The free pointer never passes the pool size
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {{(32-FREE_W){1'b0}}, next_free_reg} <= POOL_NODES)
        else $error("free pointer beyond pool");

    // The walk only reaches allocated nodes
    a_cur_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        FREE_W'(cur_node_reg) < next_free_reg)
        else $error("walk reached an unallocated node");

    // A finished word returns the walk to the root
    a_back_root: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (cur_node_reg == '0) && !missed_reg)
        else $error("walk not back at root after a word");

    // A result never reports found and overflow together
    a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(found_reg && pool_full_reg))
        else $error("found and pool_full both set");

    // A result is loaded only into a free output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.finish)
        else $error("pending result overwritten");

endmodule

@@ hw/rtl/trie_word_dictionary.sv @@
`timescale 1ns / 1ps

// Trie dictionary of words over an alphabet of ALPHABET_SIZE letters, held in a pool of
// POOL_NODES nodes. Feed one item per letter (or one empty-word item) with the
// operation and a last mark; a result comes out on the last item of each word only.
// After reset the link and end-mark stores are cleared one entry per cycle, over all
// POOL_NODES * ALPHABET_SIZE link entries (26624 at the defaults); in_ready stays low
// meanwhile. Each item passes through the registered read of the child-link store,
// then the step, any node allocation and the end-mark read; a last item then forms the
// result and sets any end mark, after any wait for out_ready while the output register
// still holds the previous result. A new item is taken only once the previous is through.
module trie_word_dictionary #(
    parameter int POOL_NODES    = 1024,
    parameter int ALPHABET_SIZE = 26
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] action,
    input  logic [4:0] letter,
    input  logic       empty_word,
    input  logic       is_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       found,
    output logic       pool_full
);

    twd_pkg::cmd_t cmd;
    twd_pkg::sts_t sts;

    // Sequence the walk
    twd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold the trie and the walk state
    twd_datapath #(
        .POOL_NODES    (POOL_NODES),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .action     (action),
        .letter     (letter),
        .empty_word (empty_word),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found      (found),
        .pool_full  (pool_full)
    );

endmodule

@@ dv/trie_word_dictionary_tb.sv @@
`timescale 1ns / 1ps

module trie_word_dictionary_tb;

    localparam int NODES   = 1024;
    localparam int LETTERS = 26;

    typedef struct packed {
        logic [1:0] act;
        logic [4:0] ltr;
        logic       empty;
        logic       last;
    } item_t;

    typedef struct packed {
        logic hit;
        logic full;
    } result_t;

    // One directed row: the item, and the answer when it is typed in by hand
    typedef struct packed {
        item_t   it;
        logic    typed;
        result_t given;
    } row_t;

    typedef struct packed {
        logic [5:0]      len;
        logic [31:0][4:0] ch;
    } word_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] action;
    logic [4:0] letter;
    logic       empty_word;
    logic       is_last;
    logic       out_valid;
    logic       out_ready;
    logic       found;
    logic       pool_full;

    // Trie copy kept by the testbench
    bit [9:0]    kid_link [NODES * LETTERS];
    bit          word_mark [NODES];
    int unsigned at_node = 0;
    bit          walk_lost = 1'b0;
    int unsigned free_node = 1;

    result_t     answers_due [$];
    word_t       known [$];
    row_t        directed [25];
    int unsigned items_sent = 0;
    int unsigned pool_overflows = 0;
    int unsigned mismatches = 0;
    int unsigned tx_idle_pct = 10;
    int unsigned rx_idle_pct = 65;

    trie_word_dictionary #(
        .POOL_NODES    (NODES),
        .ALPHABET_SIZE (LETTERS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .letter     (letter),
        .empty_word (empty_word),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found      (found),
        .pool_full  (pool_full)
    );

    always #4 clk = ~clk;

    // Advance the trie copy by one item and form the answer on the last one
    task automatic walk_trie(input item_t it, output bit emits, output result_t r);
        logic [1:0]  op;
        int unsigned ch;
        int unsigned slot;
        op = (it.act == twd_pkg::ACT_SPARE) ? twd_pkg::ACT_PREFIX : it.act;
        r = '0;
        emits = it.last;
        if (!it.empty && !walk_lost)
        begin
            ch = (it.ltr >= LETTERS) ? LETTERS - 1 : it.ltr;
            slot = at_node * LETTERS + ch;
            if (kid_link[slot] != 0)
                at_node = kid_link[slot];
            else if (op != twd_pkg::ACT_INSERT || free_node >= NODES)
                walk_lost = 1'b1;
            else
            begin
                kid_link[slot] = free_node[9:0];
                at_node = free_node;
                free_node++;
            end
        end
        if (it.last)
        begin
            case (op)
                twd_pkg::ACT_INSERT:
                begin
                    if (walk_lost)
                    begin
                        r.full = 1'b1;
                        pool_overflows++;
                    end
                    else
                    begin
                        word_mark[at_node] = 1'b1;
                        r.hit = 1'b1;
                    end
                end
                twd_pkg::ACT_SEARCH: r.hit = !walk_lost && word_mark[at_node];
                default:             r.hit = !walk_lost;
            endcase
            at_node = 0;
            walk_lost = 1'b0;
        end
    endtask

    function automatic item_t mk_item(logic [1:0] act, logic [4:0] ltr, logic empty, logic last);
        item_t it;
        it.act = act;
        it.ltr = ltr;
        it.empty = empty;
        it.last = last;
        return it;
    endfunction

    function automatic row_t mk_row(logic [1:0] act, logic [4:0] ltr, logic empty, logic last,
                                    logic typed, logic hit, logic full);
        row_t row;
        row.it = mk_item(act, ltr, empty, last);
        row.typed = typed;
        row.given.hit = hit;
        row.given.full = full;
        return row;
    endfunction

    // Hold the item until it is taken, then record the answer it owes
    task automatic send_item(input item_t it, input bit use_given, input result_t given);
        bit      emits;
        result_t r;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        in_valid   <= 1'b1;
        action     <= it.act;
        letter     <= it.ltr;
        empty_word <= it.empty;
        is_last    <= it.last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        walk_trie(it, emits, r);
        if (emits)
            answers_due.push_back(use_given ? given : r);
        items_sent++;
    endtask

    // Drop valid and hold off until every owed answer has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic word_t fresh_word(int unsigned lo, int unsigned hi);
        word_t w;
        int    i;
        w = '0;
        w.len = 6'($urandom_range(hi, lo));
        for (i = 0; i < w.len; i++)
            w.ch[i] = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 26))
                                                : 5'($urandom_range(25));
        return w;
    endfunction

    // Pick a stored word, sometimes cut short or grown by one letter
    function automatic word_t recall_word();
        word_t w;
        w = known[$urandom_range(known.size() - 1)];
        if ($urandom_range(9) < 3)
            w.len = 6'($urandom_range(w.len, 1));
        else if ($urandom_range(9) < 2 && w.len < 32)
        begin
            w.ch[w.len] = 5'($urandom_range(25));
            w.len++;
        end
        return w;
    endfunction

    // Send one word, with stray empty items and mixed actions mixed in
    task automatic send_word(input logic [1:0] op, input word_t w);
        int         i;
        bit         tail_empty;
        logic [1:0] it_op;
        tail_empty = ($urandom_range(19) == 0);
        for (i = 0; i < w.len; i++)
        begin
            if ($urandom_range(24) == 0)
                send_item(mk_item(op, 5'($urandom_range(31)), 1'b1, 1'b0), 1'b0, '0);
            it_op = ($urandom_range(11) == 0) ? 2'($urandom_range(3)) : op;
            send_item(mk_item(it_op, w.ch[i], 1'b0, (i == w.len - 1) && !tail_empty),
                      1'b0, '0);
        end
        if (tail_empty)
            send_item(mk_item(op, 5'($urandom_range(31)), 1'b1, 1'b1), 1'b0, '0);
    endtask

    task automatic random_words(input int unsigned count, input bit fill);
        int unsigned stop_at;
        int unsigned pick;
        word_t       w;
        logic [1:0]  op;
        stop_at = items_sent + count;
        while (items_sent < stop_at || (fill && pool_overflows < 8))
        begin
            pick = $urandom_range(99);
            if (pick < 3)
                send_item(mk_item(2'($urandom_range(3)), 5'($urandom_range(31)), 1'b1, 1'b1),
                          1'b0, '0);
            else if (pick < 38 || known.size() == 0 || (fill && free_node < NODES && pick < 70))
            begin
                w = (fill && free_node < NODES) ? fresh_word(10, 24) : fresh_word(1, 8);
                known.push_back(w);
                if (known.size() > 256)
                    void'(known.pop_front());
                send_word(twd_pkg::ACT_INSERT, w);
            end
            else if (pick < 45)
                send_word(twd_pkg::ACT_INSERT, recall_word());
            else
            begin
                pick = $urandom_range(99);
                op = (pick < 45) ? twd_pkg::ACT_SEARCH
                   : (pick < 85) ? twd_pkg::ACT_PREFIX : twd_pkg::ACT_SPARE;
                w = ($urandom_range(9) == 0) ? fresh_word(1, 8) : recall_word();
                send_word(op, w);
            end
        end
    endtask

    // Take results when ready and compare with the oldest owed answer
    always @(posedge clk)
    begin : rx_check
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (answers_due.size() == 0)
            begin
                $display("%0t: result with none owed: found=%0b pool_full=%0b",
                         $time, found, pool_full);
                mismatches++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (want.hit !== found)
                begin
                    $display("%0t: found expected %0b got %0b", $time, want.hit, found);
                    mismatches++;
                end
                if (want.full !== pool_full)
                begin
                    $display("%0t: pool_full expected %0b got %0b",
                             $time, want.full, pool_full);
                    mismatches++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial
    begin
        #(8_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        action     <= twd_pkg::ACT_INSERT;
        letter     <= '0;
        empty_word <= 1'b0;
        is_last    <= 1'b0;
        out_ready  <= 1'b0;

        // Empty dictionary, empty word, saturation, misses, spare action, mixed walks
        directed[0]  = mk_row(twd_pkg::ACT_SEARCH, 5'd0,  1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
        directed[1]  = mk_row(twd_pkg::ACT_PREFIX, 5'd0,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
        directed[2]  = mk_row(twd_pkg::ACT_INSERT, 5'd31, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
        directed[3]  = mk_row(twd_pkg::ACT_SEARCH, 5'd0,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
        directed[4]  = mk_row(twd_pkg::ACT_INSERT, 5'd0,  1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
        directed[5]  = mk_row(twd_pkg::ACT_INSERT, 5'd25, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        directed[6]  = mk_row(twd_pkg::ACT_INSERT, 5'd31, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
        directed[7]  = mk_row(twd_pkg::ACT_SEARCH, 5'd25, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        directed[8]  = mk_row(twd_pkg::ACT_SEARCH, 5'd26, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
        directed[9]  = mk_row(twd_pkg::ACT_PREFIX, 5'd25, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
        directed[10] = mk_row(twd_pkg::ACT_SEARCH, 5'd25, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
        directed[11] = mk_row(twd_pkg::ACT_SEARCH, 5'd1,  1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
        directed[12] = mk_row(twd_pkg::ACT_PREFIX, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        directed[13] = mk_row(twd_pkg::ACT_PREFIX, 5'd2,  1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
        directed[14] = mk_row(twd_pkg::ACT_SPARE,  5'd0,  1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
        directed[15] = mk_row(twd_pkg::ACT_INSERT, 5'd2,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        directed[16] = mk_row(twd_pkg::ACT_INSERT, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        directed[17] = mk_row(twd_pkg::ACT_SEARCH, 5'd3,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        directed[18] = mk_row(twd_pkg::ACT_INSERT, 5'd2,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        directed[19] = mk_row(twd_pkg::ACT_INSERT, 5'd0,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
        directed[20] = mk_row(twd_pkg::ACT_SEARCH, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        directed[21] = mk_row(twd_pkg::ACT_SEARCH, 5'd2,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        directed[22] = mk_row(twd_pkg::ACT_INSERT, 5'd16, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        directed[23] = mk_row(twd_pkg::ACT_INSERT, 5'd15, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        directed[24] = mk_row(twd_pkg::ACT_PREFIX, 5'd16, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Light sender gaps, heavy receiver stalls
        for (i = 0; i < 25; i++)
            send_item(directed[i].it, directed[i].typed, directed[i].given);
        drain();
        random_words(250, 1'b0);
        drain();
        random_words(250, 1'b0);

        // Heavy sender gaps, light receiver stalls
        drain();
        tx_idle_pct = 65;
        rx_idle_pct = 10;
        random_words(500, 1'b0);

        // Full rate; fill the node pool and run past it
        drain();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_words(500, 1'b1);

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
